// File: rtl/assert_macros.svh
// Assertion macros for the RTL files of the format string position checker; only the top level uses them.
// Depends on nothing; files that check their own logic include it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define FSPC_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define FSPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/fspc_pkg.sv
// Shared types, character codes and the byte classifier of the format checker.
// Depends on nothing; used by the front, back and top level.
package fspc_pkg;

   // Character codes the scanner reacts to.
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_N_LOWER = 8'h6E;
   localparam logic [7:0] CH_DOLLAR  = 8'h24;
   localparam logic [7:0] CH_LESS    = 8'h3C;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_HASH    = 8'h23;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_COMMA   = 8'h2C;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;

   // Widths of the stream data buses.
   localparam int unsigned REQ_DATA_W = 8;
   localparam int unsigned RSP_DATA_W = 8;

   // Classified form of one request byte, as it travels through the queue.
   typedef struct packed {
      logic last;      // final byte of the string
      logic percent;   // '%'
      logic n_letter;  // 'n'
      logic digit;     // '0' to '9'
      logic less;      // '<'
      logic dollar;    // '$'
      logic flag;      // flag character or digit
      logic time_ltr;  // time conversion letter
   } class_type;

   // Time conversion letters: D F K M W Z k m w y z.
   function automatic logic is_time_letter(input logic [7:0] c);
      logic hit;
      begin
         unique case (c)
            8'h44, 8'h46, 8'h4B, 8'h4D, 8'h57, 8'h5A,
            8'h6B, 8'h6D, 8'h77, 8'h79, 8'h7A: hit = 1'b1;
            default: hit = 1'b0;
         endcase
         return hit;
      end
   endfunction

   // Reduce a byte to the few properties the mode machine looks at.
   function automatic class_type classify(input logic [7:0] c, input logic last);
      class_type k;
      logic      dig;
      begin
         dig        = (c >= CH_ZERO) && (c <= CH_NINE);
         k.last     = last;
         k.percent  = (c == CH_PERCENT);
         k.n_letter = (c == CH_N_LOWER);
         k.digit    = dig;
         k.less     = (c == CH_LESS);
         k.dollar   = (c == CH_DOLLAR);
         k.flag     = dig || (c == CH_MINUS) || (c == CH_HASH) || (c == CH_PLUS) ||
                      (c == CH_SPACE) || (c == CH_COMMA) || (c == CH_LPAREN);
         k.time_ltr = is_time_letter(c);
         return k;
      end
   endfunction

endpackage

// File: rtl/fspc_front.sv
// Front end: accepts request bytes, classifies them and holds them in a small queue.
// Depends on fspc_pkg for the class type and the classifier.
module fspc_front #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [7:0]          in_ch,
   input  logic                in_last,
   output logic                out_valid,
   input  logic                out_pop,
   output fspc_pkg::class_type out_class
);
   import fspc_pkg::*;

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   class_type            mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 push;
   logic                 pop;

   // Handshake on both sides of the queue.
   assign in_ready  = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign push      = in_valid && in_ready;
   assign pop       = out_pop && out_valid;
   assign out_class = mem_ff[rd_ptr_ff];

   // Pointer and fill count update, wrapping at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage holds the classified byte; no reset needed.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= classify(in_ch, in_last);
      end
   end

endmodule

// File: rtl/fspc_back.sv
// Back end: runs the specifier mode machine on classified bytes and registers the verdict.
// Depends on fspc_pkg for the class type and bus widths.
module fspc_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_valid,
   input  fspc_pkg::class_type            q_class,
   output logic                           q_pop,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [fspc_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import fspc_pkg::*;

   localparam logic [2:0] MODE_NORMAL = 3'd0;
   localparam logic [2:0] MODE_PCT    = 3'd1;
   localparam logic [2:0] MODE_DIGITS = 3'd2;
   localparam logic [2:0] MODE_LT     = 3'd3;
   localparam logic [2:0] MODE_FLAGS  = 3'd4;

   logic [2:0] mode_ff, mode_in, mode_step;
   logic [1:0] arg_ff, arg_in, arg_step, arg_inc;
   logic       unord_ff, unord_in, unord_step;
   logic       time_ff, time_in, time_step;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_ok_ff, rsp_ok_in;
   logic       rsp_time_ff, rsp_time_in;
   logic [2:0] fb_mode;
   logic       fb_time;
   logic       verdict_ok;

   // A non-final byte always drains; a final byte needs room in the output register.
   assign q_pop = q_valid && (!q_class.last || !rsp_valid_ff || rsp_tready);

   // Leaving the flags part: a flag stays, anything else ends the specifier.
   assign fb_mode = q_class.flag ? MODE_FLAGS : MODE_NORMAL;
   assign fb_time = !q_class.flag && q_class.time_ltr;
   assign arg_inc = arg_ff[1] ? arg_ff : arg_ff + 2'd1;

   // One step of the mode machine; a seen time letter freezes the scan.
   always_comb begin
      mode_step  = mode_ff;
      arg_step   = arg_ff;
      unord_step = unord_ff;
      time_step  = time_ff;
      if (!time_ff) begin
         unique case (mode_ff)
            MODE_PCT: begin
               if (q_class.percent || q_class.n_letter) begin
                  mode_step = MODE_NORMAL;
               end else begin
                  arg_step = arg_inc;
                  if (q_class.digit) begin
                     mode_step = MODE_DIGITS;
                  end else if (q_class.less) begin
                     unord_step = 1'b1;
                     mode_step  = MODE_LT;
                  end else begin
                     unord_step = 1'b1;
                     mode_step  = fb_mode;
                     time_step  = fb_time;
                  end
               end
            end
            MODE_DIGITS: begin
               if (!q_class.digit) begin
                  if (!q_class.dollar) begin
                     unord_step = 1'b1;
                  end
                  mode_step = fb_mode;
                  time_step = fb_time;
               end
            end
            MODE_LT: begin
               if (q_class.dollar) begin
                  mode_step = MODE_FLAGS;
               end else begin
                  mode_step = fb_mode;
                  time_step = fb_time;
               end
            end
            MODE_FLAGS: begin
               mode_step = fb_mode;
               time_step = fb_time;
            end
            default: begin
               mode_step = (q_class.percent && !q_class.last) ? MODE_PCT : MODE_NORMAL;
            end
         endcase
      end
   end

   // The verdict uses the state as it stands after the final byte.
   assign verdict_ok = time_step || !(arg_step[1] && unord_step);

   // Commit the step; a final byte clears the scan state and loads the response.
   always_comb begin
      mode_in      = mode_ff;
      arg_in       = arg_ff;
      unord_in     = unord_ff;
      time_in      = time_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_time_in  = rsp_time_ff;
      if (q_pop) begin
         if (q_class.last) begin
            mode_in      = MODE_NORMAL;
            arg_in       = '0;
            unord_in     = 1'b0;
            time_in      = 1'b0;
            rsp_valid_in = 1'b1;
            rsp_ok_in    = verdict_ok;
            rsp_time_in  = time_step;
         end else begin
            mode_in  = mode_step;
            arg_in   = arg_step;
            unord_in = unord_step;
            time_in  = time_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_NORMAL;
         arg_ff       <= '0;
         unord_ff     <= 1'b0;
         time_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         arg_ff       <= arg_in;
         unord_ff     <= unord_in;
         time_ff      <= time_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload needs no reset.
   always_ff @(posedge clock) begin
      rsp_ok_ff   <= rsp_ok_in;
      rsp_time_ff <= rsp_time_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - 2)'(0), rsp_time_ff, rsp_ok_ff};

endmodule

// File: rtl/format_string_position_checker.sv
// Channel   | Ports                          | Carries
// request   | req_tvalid/tready/tdata/tlast  | one format string byte, tlast on the final byte
// response  | rsp_tvalid/tready/tdata        | one verdict per string
//
// One request byte is taken every cycle while the queue has room.
// rsp_tvalid rises after the final byte is accepted, has passed through the queue and has
// been loaded into the output register.
// Reset is synchronous and active high; it empties the queue and clears the scan state.
// A stalled response holds only final bytes; other bytes keep draining from the queue,
// and QUEUE_DEPTH (2 or more) bytes are absorbed before req_tready drops.
// Depends on fspc_pkg, fspc_front, fspc_back and assert_macros.svh.
`include "assert_macros.svh"

module format_string_position_checker #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [fspc_pkg::REQ_DATA_W-1:0] req_tdata,  // [7:0] ch
   input  logic                            req_tlast,  // is_last
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [fspc_pkg::RSP_DATA_W-1:0] rsp_tdata   // [0] format_ok, [1] time_shortcut
);
   import fspc_pkg::*;

   class_type q_class;
   logic      q_valid;
   logic      q_pop;

   // Front end: classify and queue request bytes.
   fspc_front #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_ch     (req_tdata[7:0]),
      .in_last   (req_tlast),
      .out_valid (q_valid),
      .out_pop   (q_pop),
      .out_class (q_class)
   );

   // Back end: mode machine and response register.
   fspc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_class    (q_class),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // A new response must come from a final byte popped in the cycle before.
   `FSPC_ASSERT_IMPLIES(a_rsp_from_last, clock, reset, $rose(rsp_tvalid), $past(q_pop && q_class.last), "response without a final byte")
   // The time shortcut only ever accepts.
   `FSPC_ASSERT_IMPLIES(a_time_accepts, clock, reset, rsp_tvalid && rsp_tdata[1], rsp_tdata[0], "time shortcut with a rejected verdict")
   // Back pressure on requests only comes from a queue holding bytes.
   `FSPC_ASSERT_IMPLIES(a_full_not_empty, clock, reset, !req_tready, q_valid, "request stalled while queue is empty")

endmodule
